// ===== sv/matrix_multiply_transposed_b_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply block
// Shared property forms for the assertions that close the block's modules.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_TRANSPOSED_B_MACROS_SVH
`define MATRIX_MULTIPLY_TRANSPOSED_B_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMTB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mmtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmtb_pkg
// Types and fixed constants shared by the matrix multiply modules.
// ----------------------------------------------------------------------------
package mmtb_pkg;

	// Field widths fixed by the stream and register formats.
	localparam int IDX_W   = 3;
	localparam int DIM_W   = 4;
	localparam int SUM_W   = 40;
	localparam int FUNC_W  = 2;
	localparam int OUT_W   = 48;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Dimension registers come out of reset at eight.
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// Function codes carried in the input tuser.
	localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_BT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_a;
		logic             load_bt;
		logic             issue;
		logic             first;
		logic             last_term;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] t;
		logic             last_item;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic res_moved;
	} sts_t;

endpackage

// ===== sv/matrix_multiply_transposed_b.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b
// Dense matrix multiply C = A * B with B loaded in transposed form.
// ----------------------------------------------------------------------------
// A load word (A or B-transposed element) is taken while the sequencer is
// idle. A compute word emits rows_a * cols_b result words in row-major
// order, the final one marked by tlast. Each result is built one multiply-
// accumulate per cycle through the store read, the product register and the
// accumulator; the pipeline then drains and hands the sum to the output
// register. No word is taken until the run's last sum has reached the
// output register, and a stalled output holds the sequencer in its wait
// state. Stores are not cleared; reading an element never loaded gives an
// undefined result.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// s_tdata: row_index, col_index, element, zero pad
	input  logic [((2*mmtb_pkg::IDX_W+DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// s_tuser: func
	input  logic [mmtb_pkg::FUNC_W-1:0]                     s_tuser,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	// m_tdata: out_row, out_col, product_sum, zero pad
	output logic [mmtb_pkg::OUT_W-1:0]                      m_tdata,
	output logic                                            m_tlast,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	input  logic                                            psel,
	input  logic                                            penable,
	input  logic                                            pwrite,
	input  logic [mmtb_pkg::PADDR_W-1:0]                    paddr,
	input  logic [mmtb_pkg::PDATA_W-1:0]                    pwdata,
	output logic [mmtb_pkg::PDATA_W-1:0]                    prdata,
	output logic                                            pready
);

	logic [mmtb_pkg::DIM_W-1:0]  rows_a_q, inner_dim_q, cols_b_q;
	logic                        cfg_wr;
	logic [1:0]                  cfg_idx;
	mmtb_pkg::cmd_t              cmd;
	mmtb_pkg::sts_t              sts;
	logic [mmtb_pkg::IDX_W-1:0]  ld_row, ld_col, out_row, out_col;
	logic [DATA_WIDTH-1:0]       ld_data;
	logic [mmtb_pkg::SUM_W-1:0]  out_sum;

	// Configuration registers.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mmtb_pkg::DIM_RESET;
			inner_dim_q <= mmtb_pkg::DIM_RESET;
			cols_b_q    <= mmtb_pkg::DIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mmtb_pkg::REG_ROWS_A:    rows_a_q    <= pwdata[mmtb_pkg::DIM_W-1:0];
				mmtb_pkg::REG_INNER_DIM: inner_dim_q <= pwdata[mmtb_pkg::DIM_W-1:0];
				mmtb_pkg::REG_COLS_B:    cols_b_q    <= pwdata[mmtb_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (cfg_idx)
			mmtb_pkg::REG_ROWS_A:    prdata = mmtb_pkg::PDATA_W'(rows_a_q);
			mmtb_pkg::REG_INNER_DIM: prdata = mmtb_pkg::PDATA_W'(inner_dim_q);
			mmtb_pkg::REG_COLS_B:    prdata = mmtb_pkg::PDATA_W'(cols_b_q);
			default:                 prdata = '0;
		endcase
	end

	// Input word fields.
	assign ld_row  = s_tdata[mmtb_pkg::IDX_W-1:0];
	assign ld_col  = s_tdata[2*mmtb_pkg::IDX_W-1:mmtb_pkg::IDX_W];
	assign ld_data = s_tdata[2*mmtb_pkg::IDX_W +: DATA_WIDTH];

	mmtb_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.rows_a    (rows_a_q),
		.inner_dim (inner_dim_q),
		.cols_b    (cols_b_q),
		.cmd       (cmd),
		.sts       (sts)
	);

	mmtb_dp #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.ld_row    (ld_row),
		.ld_col    (ld_col),
		.ld_data   (ld_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_sum   (out_sum),
		.out_last  (m_tlast)
	);

	// Output word packing.
	assign m_tdata = {
		{(mmtb_pkg::OUT_W - 2*mmtb_pkg::IDX_W - mmtb_pkg::SUM_W){1'b0}},
		out_sum, out_col, out_row
	};

endmodule

// ===== sv/mmtb_ram.sv =====
// ----------------------------------------------------------------------------
// mmtb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmtb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/mmtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmtb_ctrl
// Sequencer that accepts words and walks the output positions and the inner
// dimension of a compute run.
// ----------------------------------------------------------------------------
`include "matrix_multiply_transposed_b_macros.svh"

module mmtb_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mmtb_pkg::FUNC_W-1:0]  in_func,
	input  logic [mmtb_pkg::DIM_W-1:0]   rows_a,
	input  logic [mmtb_pkg::DIM_W-1:0]   inner_dim,
	input  logic [mmtb_pkg::DIM_W-1:0]   cols_b,
	output mmtb_pkg::cmd_t               cmd,
	input  mmtb_pkg::sts_t               sts
);

	mmtb_pkg::state_t              state_q, state_d;
	logic [mmtb_pkg::DIM_W-1:0]    r_q, r_d, c_q, c_d, t_q, t_d;
	logic [mmtb_pkg::DIM_W-1:0]    m_q, m_d, n_q, n_d, k_q, k_d;
	logic [mmtb_pkg::DIM_W-1:0]    m_clamp, n_clamp, k_clamp;

	// Dimension register values are used saturated to the range one to MAX_DIM.
	function automatic logic [mmtb_pkg::DIM_W-1:0] clamp_dim(
		input logic [mmtb_pkg::DIM_W-1:0] d
	);
		logic [mmtb_pkg::DIM_W-1:0] res;
		if (d == '0) begin
			res = mmtb_pkg::DIM_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			res = mmtb_pkg::DIM_W'(MAX_DIM);
		end else begin
			res = d;
		end
		return res;
	endfunction

	assign m_clamp = clamp_dim(rows_a);
	assign n_clamp = clamp_dim(inner_dim);
	assign k_clamp = clamp_dim(cols_b);

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmtb_pkg::ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			t_q     <= '0;
			m_q     <= mmtb_pkg::DIM_W'(1);
			n_q     <= mmtb_pkg::DIM_W'(1);
			k_q     <= mmtb_pkg::DIM_W'(1);
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			t_q     <= t_d;
			m_q     <= m_d;
			n_q     <= n_d;
			k_q     <= k_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		r_d           = r_q;
		c_d           = c_q;
		t_d           = t_q;
		m_d           = m_q;
		n_d           = n_q;
		k_d           = k_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.row       = r_q;
		cmd.col       = c_q;
		cmd.t         = t_q;
		cmd.last_item = (r_q == m_q - 1'b1) && (c_q == k_q - 1'b1);
		case (state_q)
			mmtb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_func)
						mmtb_pkg::FUNC_LOAD_A: begin
							cmd.load_a = 1'b1;
						end
						mmtb_pkg::FUNC_LOAD_BT: begin
							cmd.load_bt = 1'b1;
						end
						mmtb_pkg::FUNC_COMPUTE: begin
							m_d     = m_clamp;
							n_d     = n_clamp;
							k_d     = k_clamp;
							r_d     = '0;
							c_d     = '0;
							t_d     = '0;
							state_d = mmtb_pkg::ST_ISSUE;
						end
						default: begin
							// Unused code: the word is dropped.
						end
					endcase
				end
			end
			mmtb_pkg::ST_ISSUE: begin
				cmd.issue     = 1'b1;
				cmd.first     = (t_q == '0);
				cmd.last_term = (t_q == n_q - 1'b1);
				if (t_q == n_q - 1'b1) begin
					t_d     = '0;
					state_d = mmtb_pkg::ST_WAIT;
				end else begin
					t_d = t_q + 1'b1;
				end
			end
			mmtb_pkg::ST_WAIT: begin
				// Move on once the finished sum has gone to the output register.
				if (sts.res_moved) begin
					state_d = mmtb_pkg::ST_ISSUE;
					if (c_q == k_q - 1'b1) begin
						c_d = '0;
						if (r_q == m_q - 1'b1) begin
							r_d     = '0;
							state_d = mmtb_pkg::ST_IDLE;
						end else begin
							r_d = r_q + 1'b1;
						end
					end else begin
						c_d = c_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = mmtb_pkg::ST_IDLE;
			end
		endcase
	end

	`MMTB_ASSERT_SAME(a_term_in_range, state_q == mmtb_pkg::ST_ISSUE, t_q < n_q, "inner index out of range")
	`MMTB_ASSERT_SAME(a_pos_in_range, state_q != mmtb_pkg::ST_IDLE, (r_q < m_q) && (c_q < k_q), "output position out of range")
	`MMTB_ASSERT_SAME(a_move_in_wait, sts.res_moved, state_q == mmtb_pkg::ST_WAIT, "result moved outside the wait state")

endmodule

// ===== sv/mmtb_dp.sv =====
// ----------------------------------------------------------------------------
// mmtb_dp
// Element stores, multiply-accumulate pipeline and output register.
// ----------------------------------------------------------------------------
`include "matrix_multiply_transposed_b_macros.svh"

module mmtb_dp #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mmtb_pkg::cmd_t              cmd,
	output mmtb_pkg::sts_t              sts,
	input  logic [mmtb_pkg::IDX_W-1:0]  ld_row,
	input  logic [mmtb_pkg::IDX_W-1:0]  ld_col,
	input  logic [DATA_WIDTH-1:0]       ld_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mmtb_pkg::IDX_W-1:0]  out_row,
	output logic [mmtb_pkg::IDX_W-1:0]  out_col,
	output logic [mmtb_pkg::SUM_W-1:0]  out_sum,
	output logic                        out_last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int AW     = $clog2(DEPTH);
	localparam int PROD_W = 2 * DATA_WIDTH;
	// Sums wrap at 64 bits; below that the accumulator never overflows.
	localparam int ACC_W  = (PROD_W + $clog2(MAX_DIM) + 1 > 64) ? 64 :
		PROD_W + $clog2(MAX_DIM) + 1;
	localparam int EXT_W  = ACC_W + FRAC_BITS + mmtb_pkg::SUM_W;

	logic                         ld_ok;
	logic [AW-1:0]                waddr, a_raddr, b_raddr;
	logic [DATA_WIDTH-1:0]        a_rd, b_rd;
	logic                         vld_s1, first_s1, lastt_s1;
	logic                         vld_s2, first_s2, lastt_s2;
	logic signed [PROD_W-1:0]     prod_s2;
	logic signed [ACC_W-1:0]      acc_q;
	logic                         acc_full_q;
	logic signed [EXT_W-1:0]      acc_ext;
	logic                         move;
	logic                         out_valid_q, out_last_q;
	logic [mmtb_pkg::IDX_W-1:0]   out_row_q, out_col_q;
	logic [mmtb_pkg::SUM_W-1:0]   out_sum_q;

	// Load addresses; indexes past the store are dropped.
	assign ld_ok   = (int'(ld_row) < MAX_DIM) && (int'(ld_col) < MAX_DIM);
	assign waddr   = AW'(int'(ld_row) * MAX_DIM + int'(ld_col));
	assign a_raddr = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.t));
	assign b_raddr = AW'(int'(cmd.col) * MAX_DIM + int'(cmd.t));

	mmtb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (cmd.load_a && ld_ok),
		.waddr (waddr),
		.wdata (ld_data),
		.re    (cmd.issue),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	mmtb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_bt_store (
		.clk   (clk),
		.we    (cmd.load_bt && ld_ok),
		.waddr (waddr),
		.wdata (ld_data),
		.re    (cmd.issue),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	// Control tags travel alongside the read data and the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			lastt_s1 <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			lastt_s2 <= 1'b0;
		end else begin
			vld_s1   <= cmd.issue;
			first_s1 <= cmd.first;
			lastt_s1 <= cmd.last_term;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			lastt_s2 <= lastt_s1;
		end
	end

	// Product register.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= $signed(a_rd) * $signed(b_rd);
		end
	end

	// Accumulator; the first term of a dot product replaces the old sum.
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign move = acc_full_q && (!out_valid_q || out_ready);

	// Finished-sum flag and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (vld_s2 && lastt_s2) begin
				acc_full_q <= 1'b1;
			end else if (move) begin
				acc_full_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic shift right by FRAC_BITS, keeping the low result bits.
	assign acc_ext = EXT_W'(acc_q);

	// Output payload; the controller holds the position while it waits.
	always_ff @(posedge clk) begin
		if (move) begin
			out_row_q  <= cmd.row[mmtb_pkg::IDX_W-1:0];
			out_col_q  <= cmd.col[mmtb_pkg::IDX_W-1:0];
			out_last_q <= cmd.last_item;
			out_sum_q  <= acc_ext[FRAC_BITS +: mmtb_pkg::SUM_W];
		end
	end

	assign sts.res_moved = move;
	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign out_sum       = out_sum_q;
	assign out_last      = out_last_q;

	`MMTB_ASSERT_SAME(a_no_overrun, vld_s2, !acc_full_q, "new term reached a finished sum")
	`MMTB_ASSERT_NEXT(a_move_shows, move, out_valid_q && !acc_full_q, "moved sum not shown")
	`MMTB_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(out_sum_q), "stalled word changed")

endmodule

// ===== test/matrix_multiply_transposed_b_checker.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b_checker
// Watches the load/compute stream, the result stream and the register port.
// It keeps its own copy of both matrix stores and the dimension registers.
// For each compute word it queues the C elements the block must emit.
// Every result word is then compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b_checker
	import mmtb_pkg::*;
#(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// s_tdata: row_index, col_index, element, zero pad
	input  logic [((2*IDX_W+DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
	// s_tuser: func
	input  logic [FUNC_W-1:0]                               s_tuser,
	input  logic                                            s_tvalid,
	input  logic                                            s_tready,
	// m_tdata: out_row, out_col, product_sum, zero pad
	input  logic [OUT_W-1:0]                                m_tdata,
	input  logic                                            m_tlast,
	input  logic                                            m_tvalid,
	input  logic                                            m_tready,
	input  logic                                            psel,
	input  logic                                            penable,
	input  logic                                            pwrite,
	input  logic [PADDR_W-1:0]                              paddr,
	input  logic [PDATA_W-1:0]                              pwdata,
	input  logic [PDATA_W-1:0]                              prdata,
	input  logic                                            pready,
	output int                                              fail_count,
	output int                                              pending_results,
	output int                                              results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// One C element as the block must emit it.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [SUM_W-1:0] sum;
		logic             last;
	} c_elem_t;

	logic signed [DATA_WIDTH-1:0] a_mat  [MAX_DIM][MAX_DIM];
	logic signed [DATA_WIDTH-1:0] bt_mat [MAX_DIM][MAX_DIM];
	logic [DIM_W-1:0]             dim_reg [3];
	c_elem_t                      c_elem_q [$];

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// A dimension register outside 1..MAX_DIM is used saturated.
	function automatic int used_dim(input logic [DIM_W-1:0] d);
		if (d < 1)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	// Queue every C element of one compute run in row-major order.
	task automatic queue_product_run();
		int      m;
		int      n;
		int      k;
		longint  acc;
		c_elem_t e;
		m = used_dim(dim_reg[REG_ROWS_A]);
		n = used_dim(dim_reg[REG_INNER_DIM]);
		k = used_dim(dim_reg[REG_COLS_B]);
		for (int r = 0; r < m; r++) begin
			for (int c = 0; c < k; c++) begin
				acc = 0;
				for (int t = 0; t < n; t++)
					acc += longint'(a_mat[r][t]) * longint'(bt_mat[c][t]);
				// Arithmetic shift rounds toward minus infinity.
				e.row  = IDX_W'(r);
				e.col  = IDX_W'(c);
				e.sum  = SUM_W'(acc >>> FRAC_BITS);
				e.last = (r == m - 1) && (c == k - 1);
				c_elem_q.push_back(e);
			end
		end
	endtask

	// Apply one accepted input word to the store copies.
	task automatic apply_input_word();
		logic [FUNC_W-1:0]     func;
		logic [IDX_W-1:0]      row;
		logic [IDX_W-1:0]      col;
		logic [DATA_WIDTH-1:0] value;
		func  = s_tuser;
		row   = s_tdata[IDX_W-1:0];
		col   = s_tdata[2*IDX_W-1:IDX_W];
		value = s_tdata[2*IDX_W +: DATA_WIDTH];
		case (func)
			FUNC_LOAD_A:  a_mat[row][col] = value;
			FUNC_LOAD_BT: bt_mat[row][col] = value;
			FUNC_COMPUTE: queue_product_run();
			default: ;
		endcase
	endtask

	// Compare one result word with the oldest expected C element.
	task automatic check_result_word();
		c_elem_t want;
		if (c_elem_q.size() == 0) begin
			report_mismatch($sformatf("result word with nothing expected: row %0d col %0d",
				m_tdata[IDX_W-1:0], m_tdata[2*IDX_W-1:IDX_W]));
			return;
		end
		want = c_elem_q.pop_front();
		results_checked++;
		if (m_tdata[IDX_W-1:0] !== want.row)
			report_mismatch($sformatf("out_row got %0d, expected %0d",
				m_tdata[IDX_W-1:0], want.row));
		if (m_tdata[2*IDX_W-1:IDX_W] !== want.col)
			report_mismatch($sformatf("out_col got %0d, expected %0d",
				m_tdata[2*IDX_W-1:IDX_W], want.col));
		if (m_tdata[2*IDX_W +: SUM_W] !== want.sum)
			report_mismatch($sformatf("product_sum at (%0d,%0d) got %0d, expected %0d",
				want.row, want.col, $signed(m_tdata[2*IDX_W +: SUM_W]), $signed(want.sum)));
		if (m_tlast !== want.last)
			report_mismatch($sformatf("last at (%0d,%0d) got %b, expected %b",
				want.row, want.col, m_tlast, want.last));
	endtask

	// Register port, result channel, then input channel at each edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_reg[REG_ROWS_A]    = DIM_RESET;
			dim_reg[REG_INNER_DIM] = DIM_RESET;
			dim_reg[REG_COLS_B]    = DIM_RESET;
			c_elem_q.delete();
		end else begin
			if (psel && penable && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ROWS_A, REG_INNER_DIM, REG_COLS_B: begin
						if (pwrite)
							dim_reg[paddr[PADDR_W-1:2]] = pwdata[DIM_W-1:0];
						else if (prdata !== PDATA_W'(dim_reg[paddr[PADDR_W-1:2]]))
							report_mismatch($sformatf("register %0d read %0h, expected %0h",
								paddr[PADDR_W-1:2], prdata, dim_reg[paddr[PADDR_W-1:2]]));
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result_word();
			if (s_tvalid && s_tready)
				apply_input_word();
		end
		pending_results = c_elem_q.size();
	end

endmodule

// ===== test/matrix_multiply_transposed_b_test.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b_test
// Stimulus and verdict for the transposed-B matrix multiply block.
// A short directed part loads extreme values and computes three times. Then each
// of four handshake pacing phases runs three dimension settings, with random
// load sequences that always complete the elements in use before a compute.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mmtb_pkg::*;

	localparam int MAX_DIM       = 8;
	localparam int DATA_WIDTH    = 24;
	localparam int FRAC_BITS     = 16;
	localparam int S_W           = ((2*IDX_W+DATA_WIDTH+7)/8)*8;
	localparam int SETTLE_CYCLES = 16;
	localparam int SETTINGS_N    = 12;
	localparam int BATCH_WORDS   = 30;

	// The fourth function code is unused and must be ignored.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam logic [DATA_WIDTH-1:0] ELEM_MAX  = 24'h7FFFFF;
	localparam logic [DATA_WIDTH-1:0] ELEM_MIN  = 24'h800000;
	localparam logic [DATA_WIDTH-1:0] ELEM_NEG1 = 24'hFFFFFF;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic [S_W-1:0]       s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int send_idle_pct;
	int recv_stall_pct;
	int word_count;
	int compute_count;
	int setting_count;
	int fail_count;
	int pending_results;
	int results_checked;

	// Which store elements have been loaded, and the current dimensions.
	bit               a_loaded  [MAX_DIM][MAX_DIM];
	bit               bt_loaded [MAX_DIM][MAX_DIM];
	logic [DIM_W-1:0] dim_val   [3];

	always #5 clk = ~clk;

	matrix_multiply_transposed_b #(
		.MAX_DIM(MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	matrix_multiply_transposed_b_checker #(
		.MAX_DIM(MAX_DIM),
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count),
		.pending_results(pending_results),
		.results_checked(results_checked)
	);

	// The result receiver stalls at random with the current rate.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop in case the block hangs.
	initial begin
		#20ms;
		$display("FAIL matrix_multiply_transposed_b");
		$finish;
	end

	function automatic int used_dim(input logic [DIM_W-1:0] d);
		if (d < 1)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	// Mostly random values, with the extremes and small signed values mixed in.
	function automatic logic [DATA_WIDTH-1:0] pick_element();
		case ($urandom_range(9))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return '0;
			3: return ELEM_NEG1;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	// Present one word, with random idle cycles first, and wait for it to go.
	// Returns at the falling edge after acceptance with tvalid still high.
	task automatic send_word(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_WIDTH-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(S_W-2*IDX_W-DATA_WIDTH){1'b0}}, value, col, row};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		if (func != FUNC_UNUSED)
			word_count++;
		if (func == FUNC_COMPUTE)
			compute_count++;
	endtask

	task automatic load_element(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_WIDTH-1:0] value);
		send_word(func, row, col, value);
		if (func == FUNC_LOAD_A)
			a_loaded[row][col] = 1'b1;
		else if (func == FUNC_LOAD_BT)
			bt_loaded[row][col] = 1'b1;
	endtask

	// Drop tvalid and wait until every expected word is out and the block is quiet.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register transfer: setup, access, then psel low again.
	task automatic reg_access(input logic wr, input logic [1:0] idx,
			input logic [DIM_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(PDATA_W-DIM_W){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
			input logic [DIM_W-1:0] cols);
		reg_access(1'b1, REG_ROWS_A, rows);
		reg_access(1'b1, REG_INNER_DIM, inner);
		reg_access(1'b1, REG_COLS_B, cols);
		reg_access(1'b0, REG_ROWS_A, '0);
		reg_access(1'b0, REG_INNER_DIM, '0);
		reg_access(1'b0, REG_COLS_B, '0);
		dim_val[REG_ROWS_A]    = rows;
		dim_val[REG_INNER_DIM] = inner;
		dim_val[REG_COLS_B]    = cols;
		setting_count++;
	endtask

	// Load whatever the next compute reads and has never been loaded, then compute.
	task automatic fill_and_compute();
		int m;
		int n;
		int k;
		m = used_dim(dim_val[REG_ROWS_A]);
		n = used_dim(dim_val[REG_INNER_DIM]);
		k = used_dim(dim_val[REG_COLS_B]);
		for (int r = 0; r < m; r++)
			for (int t = 0; t < n; t++)
				if (!a_loaded[r][t])
					load_element(FUNC_LOAD_A, IDX_W'(r), IDX_W'(t), pick_element());
		for (int c = 0; c < k; c++)
			for (int t = 0; t < n; t++)
				if (!bt_loaded[c][t])
					load_element(FUNC_LOAD_BT, IDX_W'(c), IDX_W'(t), pick_element());
		// Index and element fields are don't-care here; drive them at random.
		send_word(FUNC_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), DATA_WIDTH'($urandom));
	endtask

	// A random load: mostly inside the region in use, sometimes anywhere,
	// now and then an unused function code.
	task automatic random_load();
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		int                rows_in_use;
		func = $urandom_range(1) ? FUNC_LOAD_BT : FUNC_LOAD_A;
		rows_in_use = used_dim(func == FUNC_LOAD_A ? dim_val[REG_ROWS_A] : dim_val[REG_COLS_B]);
		if ($urandom_range(99) < 8)
			func = FUNC_UNUSED;
		if ($urandom_range(99) < 75) begin
			row = IDX_W'($urandom_range(rows_in_use - 1));
			col = IDX_W'($urandom_range(used_dim(dim_val[REG_INNER_DIM]) - 1));
		end else begin
			row = IDX_W'($urandom);
			col = IDX_W'($urandom);
		end
		load_element(func, row, col, pick_element());
	endtask

	// Load sequences of random length, each closed by a compute.
	task automatic run_batch(input int budget);
		int first_word;
		first_word = word_count;
		while (word_count - first_word < budget) begin
			repeat ($urandom_range(1, 10)) random_load();
			fill_and_compute();
		end
	endtask

	initial begin
		int               send_pct [4];
		int               recv_pct [4];
		logic [DIM_W-1:0] dim_tab  [SETTINGS_N][3];
		send_pct = '{0, 52, 0, 38};
		recv_pct = '{0, 0, 52, 38};
		dim_tab = '{
			'{4'd1, 4'd1, 4'd1}, '{4'd8, 4'd8, 4'd8}, '{4'd0, 4'd0, 4'd0},
			'{4'd15, 4'd15, 4'd15}, '{4'd1, 4'd8, 4'd1}, '{4'd8, 4'd1, 4'd8},
			'{4'd3, 4'd5, 4'd2}, '{4'd2, 4'd1, 4'd7}, '{4'd9, 4'd4, 4'd3},
			'{4'd5, 4'd12, 4'd6}, '{4'd7, 4'd3, 4'd0}, '{4'd4, 4'd8, 4'd5}
		};
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		word_count     = 0;
		compute_count  = 0;
		setting_count  = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme values and signs in a 2x2x2 product, the top
		// corner indexes, an unused function code, and a repeated compute.
		set_dims(4'd2, 4'd2, 4'd2);
		load_element(FUNC_LOAD_A, 3'd0, 3'd0, ELEM_MAX);
		load_element(FUNC_LOAD_A, 3'd0, 3'd1, ELEM_MAX);
		load_element(FUNC_LOAD_A, 3'd1, 3'd0, ELEM_MIN);
		load_element(FUNC_LOAD_A, 3'd1, 3'd1, 24'd1);
		load_element(FUNC_LOAD_BT, 3'd0, 3'd0, ELEM_MAX);
		load_element(FUNC_LOAD_BT, 3'd0, 3'd1, ELEM_MAX);
		load_element(FUNC_LOAD_BT, 3'd1, 3'd0, ELEM_MIN);
		load_element(FUNC_LOAD_BT, 3'd1, 3'd1, ELEM_NEG1);
		send_word(FUNC_UNUSED, 3'd0, 3'd0, 24'h123456);
		load_element(FUNC_LOAD_A, 3'd7, 3'd7, 24'h555555);
		load_element(FUNC_LOAD_BT, 3'd7, 3'd7, 24'hAAAAAA);
		send_word(FUNC_COMPUTE, 3'd7, 3'd7, ELEM_NEG1);
		send_word(FUNC_COMPUTE, 3'd0, 3'd0, '0);
		// A small negative sum checks rounding toward minus infinity.
		load_element(FUNC_LOAD_A, 3'd0, 3'd0, 24'd1);
		load_element(FUNC_LOAD_A, 3'd0, 3'd1, '0);
		load_element(FUNC_LOAD_BT, 3'd0, 3'd0, ELEM_NEG1);
		send_word(FUNC_COMPUTE, 3'd0, 3'd0, '0);
		wait_idle();

		// Random: four pacing phases with three dimension settings each.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			for (int s = 0; s < 3; s++) begin
				set_dims(dim_tab[p*3+s][0], dim_tab[p*3+s][1], dim_tab[p*3+s][2]);
				run_batch(BATCH_WORDS);
				wait_idle();
			end
		end

		$display("Sent %0d load and compute words (%0d computes) under %0d dimension settings,",
			word_count, compute_count, setting_count);
		$display("in four pacing phases; %0d result words were checked.", results_checked);
		if (fail_count == 0)
			$display("PASS matrix_multiply_transposed_b");
		else
			$display("FAIL matrix_multiply_transposed_b");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mmtb_pkg.sv
sv/mmtb_ram.sv
sv/mmtb_ctrl.sv
sv/mmtb_dp.sv
sv/matrix_multiply_transposed_b.sv
test/matrix_multiply_transposed_b_checker.sv
test/matrix_multiply_transposed_b_test.sv
